>>> hw/rtl/lruc_pkg.sv
// Shared constants and types for the LRU cache miss simulator.
package lruc_pkg;

   localparam int ENTRIES = 64;
   localparam int ADDR_W  = 64;
   localparam int CNT_W   = 32;
   localparam int OCC_W   = 7;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } lruc_state_type;

   typedef struct packed {
      logic compare;
      logic update;
   } lruc_ctl_type;

endpackage

>>> hw/rtl/lruc_cell.sv
// One position of the LRU recency stack: tag, valid bit and registered tag match.
module lruc_cell
   import lruc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lruc_ctl_type      ctl,
   input  logic [ADDR_W-1:0] cmp_address,
   input  logic [ADDR_W-1:0] prev_address,
   input  logic              prev_valid,
   input  logic              hit_in,
   output logic [ADDR_W-1:0] address,
   output logic              valid,
   output logic              hit_out
);

   logic [ADDR_W-1:0] address_ff;
   logic              valid_ff;
   logic              match_ff;
   logic              match_in;
   logic              shift;

   assign match_in = valid_ff && (address_ff == cmp_address);
   // Every position down to and including the hit (or all of them on a miss) moves down one place.
   assign shift    = ctl.update && !hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.compare) begin
            match_ff <= match_in;
         end
         if (shift) begin
            valid_ff <= prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         address_ff <= prev_address;
      end
   end

   assign address = address_ff;
   assign valid   = valid_ff;
   assign hit_out = hit_in | match_ff;

endmodule

>>> hw/rtl/lru_cache_miss_simulator_top.sv
// Top level of the fully associative LRU cache miss simulator.
//
// req channel: one 64-bit address word per access (req_valid/req_ready).
// rsp channel: one word per access with hit flag, saturating miss count
// and occupancy after the access (rsp_valid/rsp_ready).
// The tags sit in a chain of cells ordered by recency, most recent first.
// On accept, every cell compares its tag with the address in parallel
// and registers the match. In the update step, cells down to and including
// the hit, or all cells on a miss, take their neighbor's content and the
// address enters at the head; the result is loaded into the output register.
// A new access is accepted only after the previous one has shifted through
// the cell chain in its update step.
// A result held in the output register does not block the next accept;
// when the receiver stalls, the next access waits in its update cycle and
// req_ready stays low until the output register frees up.
// Reset clears all valid bits, the miss count and the occupancy at once.
module lru_cache_miss_simulator_top
   import lruc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit,
   output logic [CNT_W-1:0]  rsp_miss_count,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   lruc_state_type    state_ff, state_in;
   lruc_ctl_type      ctl;
   logic [ADDR_W-1:0] address_ff;
   logic [CNT_W-1:0]  misses_ff, misses_in;
   logic [OCC_W-1:0]  filled_ff, filled_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [CNT_W-1:0]  rsp_miss_count_ff;
   logic [OCC_W-1:0]  rsp_occupancy_ff;
   logic              accept;
   logic              hit;

   logic [ADDR_W-1:0] chain_address [ENTRIES+1];
   logic              chain_valid   [ENTRIES+1];
   logic              chain_hit     [ENTRIES+1];

   assign chain_address[0] = address_ff;
   assign chain_valid[0]   = 1'b1;
   assign chain_hit[0]     = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lruc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .cmp_address  (req_address),
         .prev_address (chain_address[i]),
         .prev_valid   (chain_valid[i]),
         .hit_in       (chain_hit[i]),
         .address      (chain_address[i+1]),
         .valid        (chain_valid[i+1]),
         .hit_out      (chain_hit[i+1])
      );
   end

   assign hit    = chain_hit[ENTRIES];
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      ctl.compare  = 1'b0;
      ctl.update   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.compare = req_valid;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      misses_in = misses_ff;
      filled_in = filled_ff;
      if (!hit) begin
         if (misses_ff != {CNT_W{1'b1}}) begin
            misses_in = misses_ff + 1'b1;
         end
         if (filled_ff != OCC_W'(ENTRIES)) begin
            filled_in = filled_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         misses_ff    <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.update) begin
            misses_ff <= misses_in;
            filled_ff <= filled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         address_ff <= req_address;
      end
      if (ctl.update) begin
         rsp_hit_ff        <= hit;
         rsp_miss_count_ff <= misses_in;
         rsp_occupancy_ff  <= filled_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_miss_count = rsp_miss_count_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

endmodule
